// ===== src/assert_macros.svh =====
// Assertion macros shared by the voice allocator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PVA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define PVA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== src/pva_pkg.sv =====
// Package for the priority voice allocator: sizes, codes and the entry type.
// Depends on nothing; used by the channel interfaces and the core.
`timescale 1ns / 1ps

package pva_pkg;

  localparam int MAX_VOICES = 16;
  localparam int IDX_W      = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CNT_W      = $clog2(MAX_VOICES + 1);

  localparam int MODE_W     = 2;
  localparam int HANDLE_W   = 8;
  localparam int PRIO_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int VCOUNT_W   = 5;

  localparam logic [MODE_W-1:0] MODE_PLAY   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STOP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED  = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_HANDLE = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_REMOVED   = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [PRIO_W-1:0]   prio;
  } entry_t;

endpackage

// ===== src/pva_in_if.sv =====
// Request channel of the voice allocator: valid/ready plus the request fields.
// Depends on pva_pkg for the field widths.
`timescale 1ns / 1ps

interface pva_in_if;
  logic                             valid;
  logic                             ready;
  logic [pva_pkg::MODE_W-1:0]       mode;
  logic [pva_pkg::HANDLE_W-1:0]     voice_handle;
  logic                             handle_ok;
  logic [pva_pkg::PRIO_W-1:0]       priority_req;

  modport source (output valid, output mode, output voice_handle, output handle_ok,
                  output priority_req, input ready);
  modport sink   (input valid, input mode, input voice_handle, input handle_ok,
                  input priority_req, output ready);
endinterface

// ===== src/pva_out_if.sv =====
// Result channel of the voice allocator: valid/ready plus the result fields.
// Depends on pva_pkg for the field widths.
`timescale 1ns / 1ps

interface pva_out_if;
  logic                             valid;
  logic                             ready;
  logic [pva_pkg::STATUS_W-1:0]     status;
  logic                             stop_valid;
  logic [pva_pkg::HANDLE_W-1:0]     stop_handle;
  logic [pva_pkg::VCOUNT_W-1:0]     voice_count;

  modport source (output valid, output status, output stop_valid, output stop_handle,
                  output voice_count, input ready);
  modport sink   (input valid, input status, input stop_valid, input stop_handle,
                  input voice_count, output ready);
endinterface

// ===== src/priority_voice_allocator_core.sv =====
// Top level of the priority voice allocator: voice list memory and its sequencer.
// Depends on pva_pkg, pva_in_if, pva_out_if and assert_macros.svh.
`timescale 1ns / 1ps

// The allocator keeps up to MAX_VOICES voices, oldest first, in a single
// synchronous memory of {handle, priority} entries, and answers every request
// transfer with exactly one result transfer. A play request into a list with
// room is appended straight away, and its result is registered and then moved
// to the output register. Stop and finished requests make one compaction pass
// over the N listed entries, reading one entry a cycle and writing each
// survivor back at the next free place from the bottom. A play request into a
// full list first makes a search pass for the lowest-priority, oldest entry
// and then, unless rejected, a compaction pass that drops the victim. The
// memory has a single read and a single write port, so one entry is visited
// per cycle. Requests are taken only while the sequencer is idle, but the
// result register decouples the two sides, so a new request is accepted while
// the previous result still waits for its transfer. A stop request removes
// only the oldest matching voice and reports its handle; a finished event
// removes every matching voice and reports no handle. An evicted victim is
// reported even when the new request had no handle granted.
module priority_voice_allocator_core (
  input  logic      clk,
  input  logic      rst_n,
  pva_in_if.sink    in_chan,
  pva_out_if.source out_chan
);
  import pva_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SCAN    = 4'b0010,
    ST_COMPACT = 4'b0100,
    ST_DONE    = 4'b1000
  } state_t;

  // Voice list memory, registered read.
  entry_t mem [MAX_VOICES];
  entry_t rd_data_r;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic             rd_pend_r;
  logic [IDX_W-1:0] rd_pos_r;
  logic [CNT_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic             seen_r, seen_nxt;
  logic [PRIO_W-1:0]   min_r, min_nxt;
  logic [IDX_W-1:0]    low_r, low_nxt;
  logic [HANDLE_W-1:0] low_handle_r, low_handle_nxt;

  // Request held for the duration of its processing.
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [HANDLE_W-1:0] h_r, h_nxt;
  logic                ok_r, ok_nxt;
  logic [PRIO_W-1:0]   prio_r, prio_nxt;

  // Result being assembled, then the output register.
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                res_stop_valid_r, res_stop_valid_nxt;
  logic [HANDLE_W-1:0] res_stop_handle_r, res_stop_handle_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_stop_valid_r, out_stop_valid_nxt;
  logic [HANDLE_W-1:0] out_stop_handle_r, out_stop_handle_nxt;
  logic [VCOUNT_W-1:0] out_count_r, out_count_nxt;

  logic in_fire;
  logic list_full;
  logic pass_done;
  logic skip_entry;
  logic out_free;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && (state_r == ST_IDLE);
  assign list_full     = (cnt_r == CNT_W'(MAX_VOICES));
  assign pass_done     = (rd_ptr_r == cnt_r) && !rd_pend_r;
  assign out_free      = !out_valid_r || out_chan.ready;

  assign mem_re    = ((state_r == ST_SCAN) || (state_r == ST_COMPACT)) && (rd_ptr_r < cnt_r);
  assign mem_raddr = rd_ptr_r[IDX_W-1:0];

  // Entries dropped during a compaction pass: the victim on eviction, the
  // oldest match on a stop, every match on a finished event.
  always_comb begin
    case (mode_r)
      MODE_PLAY:   skip_entry = (rd_pos_r == low_r);
      MODE_STOP:   skip_entry = (rd_data_r.handle == h_r) && !seen_r;
      MODE_FINISH: skip_entry = (rd_data_r.handle == h_r);
      default:     skip_entry = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt           = state_r;
    cnt_nxt             = cnt_r;
    rd_ptr_nxt          = rd_ptr_r;
    wr_ptr_nxt          = wr_ptr_r;
    seen_nxt            = seen_r;
    min_nxt             = min_r;
    low_nxt             = low_r;
    low_handle_nxt      = low_handle_r;
    mode_nxt            = mode_r;
    h_nxt               = h_r;
    ok_nxt              = ok_r;
    prio_nxt            = prio_r;
    res_status_nxt      = res_status_r;
    res_stop_valid_nxt  = res_stop_valid_r;
    res_stop_handle_nxt = res_stop_handle_r;
    mem_we              = 1'b0;
    mem_waddr           = wr_ptr_r[IDX_W-1:0];
    mem_wdata           = '{handle: h_r, prio: prio_r};

    if (mem_re) begin
      rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          mode_nxt            = in_chan.mode;
          h_nxt               = in_chan.voice_handle;
          ok_nxt              = in_chan.handle_ok;
          prio_nxt            = in_chan.priority_req;
          res_status_nxt      = STATUS_NOT_FOUND;
          res_stop_valid_nxt  = 1'b0;
          res_stop_handle_nxt = '0;
          rd_ptr_nxt          = '0;
          wr_ptr_nxt          = '0;
          seen_nxt            = 1'b0;
          case (in_chan.mode)
            MODE_PLAY: begin
              if (list_full) begin
                state_nxt = ST_SCAN;
              end else begin
                state_nxt = ST_DONE;
                if (in_chan.handle_ok) begin
                  mem_we         = 1'b1;
                  mem_waddr      = cnt_r[IDX_W-1:0];
                  mem_wdata      = '{handle: in_chan.voice_handle,
                                     prio: in_chan.priority_req};
                  cnt_nxt        = cnt_r + CNT_W'(1);
                  res_status_nxt = STATUS_ADDED;
                end else begin
                  res_status_nxt = STATUS_NO_HANDLE;
                end
              end
            end
            MODE_STOP, MODE_FINISH: begin
              state_nxt = ST_COMPACT;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Strict less-than keeps the oldest entry on a priority tie.
        if (rd_pend_r && ((rd_pos_r == '0) || (rd_data_r.prio < min_r))) begin
          min_nxt        = rd_data_r.prio;
          low_nxt        = rd_pos_r;
          low_handle_nxt = rd_data_r.handle;
        end
        if (pass_done) begin
          if (min_r >= prio_r) begin
            res_status_nxt = STATUS_REJECTED;
            state_nxt      = ST_DONE;
          end else begin
            rd_ptr_nxt = '0;
            wr_ptr_nxt = '0;
            seen_nxt   = 1'b0;
            state_nxt  = ST_COMPACT;
          end
        end
      end

      ST_COMPACT: begin
        if (rd_pend_r) begin
          if (skip_entry) begin
            seen_nxt = 1'b1;
          end else begin
            mem_we     = 1'b1;
            mem_waddr  = wr_ptr_r[IDX_W-1:0];
            mem_wdata  = rd_data_r;
            wr_ptr_nxt = wr_ptr_r + CNT_W'(1);
          end
        end
        if (pass_done) begin
          cnt_nxt   = wr_ptr_r;
          state_nxt = ST_DONE;
          case (mode_r)
            MODE_PLAY: begin
              res_stop_valid_nxt  = 1'b1;
              res_stop_handle_nxt = low_handle_r;
              if (ok_r) begin
                mem_we         = 1'b1;
                mem_waddr      = wr_ptr_r[IDX_W-1:0];
                mem_wdata      = '{handle: h_r, prio: prio_r};
                cnt_nxt        = wr_ptr_r + CNT_W'(1);
                res_status_nxt = STATUS_ADDED;
              end else begin
                res_status_nxt = STATUS_NO_HANDLE;
              end
            end
            MODE_STOP: begin
              if (seen_r) begin
                res_status_nxt      = STATUS_REMOVED;
                res_stop_valid_nxt  = 1'b1;
                res_stop_handle_nxt = h_r;
              end
            end
            default: begin
              if (seen_r) begin
                res_status_nxt = STATUS_REMOVED;
              end
            end
          endcase
        end
      end

      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: loaded when the result is complete and the slot is free.
  always_comb begin
    out_valid_nxt       = out_valid_r && !out_chan.ready;
    out_status_nxt      = out_status_r;
    out_stop_valid_nxt  = out_stop_valid_r;
    out_stop_handle_nxt = out_stop_handle_r;
    out_count_nxt       = out_count_r;
    if ((state_r == ST_DONE) && out_free) begin
      out_valid_nxt       = 1'b1;
      out_status_nxt      = res_status_r;
      out_stop_valid_nxt  = res_stop_valid_r;
      out_stop_handle_nxt = res_stop_handle_r;
      out_count_nxt       = VCOUNT_W'(cnt_r);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.stop_valid  = out_stop_valid_r;
  assign out_chan.stop_handle = out_stop_handle_r;
  assign out_chan.voice_count = out_count_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rd_ptr_r    <= '0;
      rd_pend_r   <= 1'b0;
      wr_ptr_r    <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      rd_pend_r   <= mem_re;
      wr_ptr_r    <= wr_ptr_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_pos_r          <= mem_raddr;
    min_r             <= min_nxt;
    low_r             <= low_nxt;
    low_handle_r      <= low_handle_nxt;
    mode_r            <= mode_nxt;
    h_r               <= h_nxt;
    ok_r              <= ok_nxt;
    prio_r            <= prio_nxt;
    res_status_r      <= res_status_nxt;
    res_stop_valid_r  <= res_stop_valid_nxt;
    res_stop_handle_r <= res_stop_handle_nxt;
    out_status_r      <= out_status_nxt;
    out_stop_valid_r  <= out_stop_valid_nxt;
    out_stop_handle_r <= out_stop_handle_nxt;
    out_count_r       <= out_count_nxt;
  end

`include "assert_macros.svh"

  `PVA_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(MAX_VOICES))
  `PVA_ASSERT_IMP(a_wr_behind_rd, clk, rst_n, (state_r == ST_COMPACT) && rd_pend_r, wr_ptr_r <= CNT_W'(rd_pos_r))
  `PVA_ASSERT_NXT(a_accept_busy, clk, rst_n, in_chan.valid && in_chan.ready, state_r != ST_IDLE)
  `PVA_ASSERT_IMP(a_reject_full, clk, rst_n, (state_r == ST_DONE) && (res_status_r == STATUS_REJECTED), list_full)
  `PVA_ASSERT_IMP(a_quiet_handle, clk, rst_n, out_valid_r && !out_stop_valid_r, out_stop_handle_r == '0)

endmodule

// ===== verif/priority_voice_allocator_core_tb.sv =====
// Self-checking testbench for priority_voice_allocator_core: a queued request driver,
// a result monitor and an in-line prediction of the voice list.
// Depends on pva_pkg, pva_in_if, pva_out_if and the allocator RTL.
`timescale 1ns / 1ps

module priority_voice_allocator_core_tb;
  import pva_pkg::*;

  // Mode 3 has no name in the package; the block must ignore it.
  localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

  localparam int RANDOM_REQUESTS = 1775;
  localparam int HOLD_CYCLES     = 400;
  localparam int HOLD_AFTER      = 300;
  // A full-list play makes a search pass and then a compaction pass over the list.
  localparam int DRAIN_CYCLES    = 2 * MAX_VOICES + 32;
  localparam int CYCLE_LIMIT     = 1_500_000;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [HANDLE_W-1:0] handle;
    logic                ok;
    logic [PRIO_W-1:0]   prio;
  } voice_request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                stop_valid;
    logic [HANDLE_W-1:0] stop_handle;
    logic [VCOUNT_W-1:0] voice_count;
  } voice_outcome_t;

  logic clk;
  logic rst_n;

  pva_in_if  in_chan();
  pva_out_if out_chan();

  priority_voice_allocator_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  voice_request_t pending_requests[$];
  voice_outcome_t expected_outcomes[$];
  // The predicted voice list, oldest entry at index 0.
  entry_t         listed_voices[$];

  int  total_requests;
  int  accepted_count;
  int  checked_count;
  int  error_count;
  int  evictions_seen;
  int  status_seen[5];
  int  src_gap;
  int  sink_stall;
  bit  src_calm;
  bit  sink_calm;
  bit  hold_off;
  int  cycle_count;

  // Clock and the single reset at the start of the run.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Every input of the block is known from time zero.
  initial begin
    in_chan.valid        = 1'b0;
    in_chan.mode         = MODE_PLAY;
    in_chan.voice_handle = '0;
    in_chan.handle_ok    = 1'b0;
    in_chan.priority_req = '0;
    out_chan.ready       = 1'b0;
    hold_off             = 1'b0;
  end

  function automatic void log_failure(input string msg);
    if (error_count < REPORT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endfunction

  // Applies one request to the predicted voice list and returns the result the
  // block should produce for it.
  function automatic voice_outcome_t allocate_voice(input voice_request_t req);
    voice_outcome_t res;
    entry_t         added;
    int             low;
    int             hit;
    bit             room;
    res.status      = STATUS_NOT_FOUND;
    res.stop_valid  = 1'b0;
    res.stop_handle = '0;
    room            = 1'b1;
    case (req.mode)
      MODE_PLAY: begin
        if (listed_voices.size() >= MAX_VOICES) begin
          // Lowest priority wins the search; strict compare keeps the oldest on a tie.
          low = 0;
          for (int i = 1; i < listed_voices.size(); i++) begin
            if (listed_voices[i].prio < listed_voices[low].prio) low = i;
          end
          if (listed_voices[low].prio >= req.prio) begin
            room       = 1'b0;
            res.status = STATUS_REJECTED;
          end else begin
            // The victim goes whether or not the new request holds a handle.
            res.stop_valid  = 1'b1;
            res.stop_handle = listed_voices[low].handle;
            listed_voices.delete(low);
          end
        end
        if (room) begin
          if (!req.ok) begin
            res.status = STATUS_NO_HANDLE;
          end else begin
            added.handle = req.handle;
            added.prio   = req.prio;
            listed_voices.insert(listed_voices.size(), added);
            res.status = STATUS_ADDED;
          end
        end
      end
      MODE_STOP: begin
        // Only the oldest voice with this handle is stopped and reported.
        hit = -1;
        for (int i = 0; i < listed_voices.size(); i++) begin
          if (hit < 0 && listed_voices[i].handle == req.handle) hit = i;
        end
        if (hit >= 0) begin
          res.stop_valid  = 1'b1;
          res.stop_handle = req.handle;
          res.status      = STATUS_REMOVED;
          listed_voices.delete(hit);
        end
      end
      MODE_FINISH: begin
        // Every voice with this handle goes, silently.
        for (int i = listed_voices.size() - 1; i >= 0; i--) begin
          if (listed_voices[i].handle == req.handle) begin
            listed_voices.delete(i);
            res.status = STATUS_REMOVED;
          end
        end
      end
      default: begin
      end
    endcase
    res.voice_count = VCOUNT_W'(listed_voices.size());
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int draw_gap();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  task automatic queue_request(input logic [MODE_W-1:0] mode, input logic [HANDLE_W-1:0] handle,
                               input logic ok, input logic [PRIO_W-1:0] prio);
    voice_request_t req;
    req.mode   = mode;
    req.handle = handle;
    req.ok     = ok;
    req.prio   = prio;
    pending_requests.insert(pending_requests.size(), req);
  endtask

  // Stimulus. The directed opening fills the list to capacity with two voices at
  // priority zero (for the oldest-on-tie rule), one at the top priority and three
  // copies of one handle, then walks through the special cases: rejection on an
  // equal priority, eviction, eviction with no handle granted, a play without a
  // handle while there is room, stop and finished on the duplicated handle, both
  // on a handle that is not listed, and the unused mode.
  initial begin
    voice_request_t req;
    int             counted;
    int             pick;
    logic [HANDLE_W-1:0] fill_handle;
    logic [PRIO_W-1:0]   fill_prio;

    for (int i = 0; i < MAX_VOICES; i++) begin
      fill_handle = HANDLE_W'(i);
      if (i == 13 || i == 14) fill_handle = 8'h05;
      if (i == 15) fill_handle = 8'hFF;
      fill_prio = PRIO_W'(8'h40 + i * 8);
      if (i == 0 || i == 3) fill_prio = 8'h00;
      if (i == 1) fill_prio = 8'hFF;
      queue_request(MODE_PLAY, fill_handle, 1'b1, fill_prio);
    end
    queue_request(MODE_PLAY,     8'h80, 1'b1, 8'h00);
    queue_request(MODE_PLAY,     8'hA0, 1'b1, 8'h10);
    queue_request(MODE_PLAY,     8'hA1, 1'b0, 8'h10);
    queue_request(MODE_PLAY,     8'hA2, 1'b0, 8'h80);
    queue_request(MODE_STOP,     8'h05, 1'b0, 8'h00);
    queue_request(MODE_FINISH,   8'h05, 1'b1, 8'hFF);
    queue_request(MODE_STOP,     8'h77, 1'b1, 8'h00);
    queue_request(MODE_FINISH,   8'h77, 1'b0, 8'h00);
    queue_request(MODE_RESERVED, 8'hFF, 1'b1, 8'hFF);

    // Random part. Handles come mostly from a pool of 32 so that stops and
    // finished events often hit, and duplicates pile up; a third of the
    // priorities sit on a coarse grid so that ties are common. Plays outweigh
    // removals so the list spends much of its time full.
    counted = 0;
    while (counted < RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 99);
      if (pick < 50)      req.mode = MODE_PLAY;
      else if (pick < 72) req.mode = MODE_STOP;
      else if (pick < 94) req.mode = MODE_FINISH;
      else                req.mode = MODE_RESERVED;
      if ($urandom_range(0, 4) == 0)
        req.handle = HANDLE_W'($urandom_range(0, 255));
      else
        req.handle = {($urandom_range(0, 1) != 0) ? 4'hF : 4'h0, 4'($urandom_range(0, 15))};
      if ($urandom_range(0, 2) == 0) req.prio = PRIO_W'($urandom_range(0, 7) * 36);
      else                           req.prio = PRIO_W'($urandom_range(0, 255));
      req.ok = ($urandom_range(0, 9) != 0);
      pending_requests.insert(pending_requests.size(), req);
      counted++;
    end
    total_requests = pending_requests.size();
  end

  // Driver. A request is predicted at the edge where its transfer happens, and
  // the next one is put on the channel in the same step, so valid stays high
  // across back-to-back transfers without ever being lowered and raised.
  always @(posedge clk) begin
    voice_request_t seen;
    voice_request_t nxt;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      src_gap       = 0;
      src_calm      = 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        seen.mode   = in_chan.mode;
        seen.handle = in_chan.voice_handle;
        seen.ok     = in_chan.handle_ok;
        seen.prio   = in_chan.priority_req;
        expected_outcomes.insert(expected_outcomes.size(), allocate_voice(seen));
        accepted_count++;
      end
      if ($urandom_range(0, 99) == 0) src_calm = ~src_calm;
      if (!in_chan.valid || in_chan.ready) begin
        // During the receiver's hold-off the sender offers without a break.
        if (src_gap > 0 && !hold_off) begin
          src_gap--;
          in_chan.valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          nxt = pending_requests.pop_front();
          in_chan.mode         <= nxt.mode;
          in_chan.voice_handle <= nxt.handle;
          in_chan.handle_ok    <= nxt.ok;
          in_chan.priority_req <= nxt.prio;
          in_chan.valid        <= 1'b1;
          if (!src_calm && $urandom_range(0, 99) < 25) src_gap = draw_gap();
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Compares each result transfer against the oldest prediction and
  // paces ready with its own random stalls, calm stretches and the hold-off.
  always @(posedge clk) begin
    voice_outcome_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      sink_stall     = 0;
      sink_calm      = 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        checked_count++;
        if (out_chan.status < 5) status_seen[out_chan.status]++;
        if (out_chan.stop_valid && out_chan.status != STATUS_REMOVED) evictions_seen++;
        if (expected_outcomes.size() == 0) begin
          log_failure($sformatf("result with nothing outstanding: status %0d stop %0b/%02h count %0d",
                                out_chan.status, out_chan.stop_valid, out_chan.stop_handle,
                                out_chan.voice_count));
        end else begin
          want = expected_outcomes.pop_front();
          if (out_chan.status !== want.status || out_chan.stop_valid !== want.stop_valid ||
              out_chan.stop_handle !== want.stop_handle ||
              out_chan.voice_count !== want.voice_count) begin
            log_failure($sformatf({"result %0d: expected status %0d stop %0b/%02h count %0d, ",
                                   "got status %0d stop %0b/%02h count %0d"},
                                  checked_count, want.status, want.stop_valid, want.stop_handle,
                                  want.voice_count, out_chan.status, out_chan.stop_valid,
                                  out_chan.stop_handle, out_chan.voice_count));
          end
        end
      end
      if ($urandom_range(0, 99) == 0) sink_calm = ~sink_calm;
      if (hold_off) begin
        out_chan.ready <= 1'b0;
      end else if (sink_stall > 0) begin
        sink_stall--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        if (!sink_calm && $urandom_range(0, 99) < 20) sink_stall = draw_gap();
      end
    end
  end

  // Long receiver hold-off, timed in its own process: the result register and
  // the sequencer fill up and the block must stall its request channel.
  initial begin
    wait (accepted_count >= HOLD_AFTER);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog on the cycle count.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles with %0d results outstanding", cycle_count,
             expected_outcomes.size());
    $display("priority_voice_allocator_core_tb: errors");
    $finish;
  end

  // End of run: every request transferred, every prediction met, then a drain
  // period in case the block produces anything further.
  initial begin
    @(posedge rst_n);
    while (total_requests == 0 || accepted_count < total_requests) @(posedge clk);
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_outcomes.size() != 0)
      log_failure($sformatf("%0d results never arrived", expected_outcomes.size()));
    $display("%0d requests transferred, %0d results checked, %0d failures", accepted_count,
             checked_count, error_count);
    $display("added %0d, rejected %0d, no handle %0d, removed %0d, not found %0d, evictions %0d",
             status_seen[STATUS_ADDED], status_seen[STATUS_REJECTED],
             status_seen[STATUS_NO_HANDLE], status_seen[STATUS_REMOVED],
             status_seen[STATUS_NOT_FOUND], evictions_seen);
    if (error_count == 0)
      $display("priority_voice_allocator_core_tb: clean");
    else
      $display("priority_voice_allocator_core_tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/pva_pkg.sv
src/pva_in_if.sv
src/pva_out_if.sv
src/priority_voice_allocator_core.sv
verif/priority_voice_allocator_core_tb.sv
